@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL; included by mrsfc_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion of a property, disabled during reset.
`define ASSERT_CLKED(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mrsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrsfc_pkg
// Types and constants shared by the Modbus RTU slave frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrsfc_pkg;

   // receive store depth and the counter that can hold it
   localparam int RX_DEPTH = 32;
   localparam int COUNT_W  = $clog2(RX_DEPTH + 1);

   // only the first bytes of a frame take part in the check and the reply
   localparam int KEEP_BYTES = 7;
   localparam int IDX_W      = 3;

   localparam logic [IDX_W-1:0] IDX_CRC_LAST   = 3'd4;
   localparam logic [IDX_W-1:0] IDX_REPLY_LAST = 3'd6;

   // request kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_GAP15 = 2'd1;
   localparam logic [1:0] KIND_GAP35 = 2'd2;

   // register indexes
   localparam logic CSR_SLAVE_ADDRESS = 1'b0;
   localparam logic CSR_FRAME_LIMIT   = 1'b1;

   localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;
   localparam logic [5:0] FRAME_LIMIT_RESET   = 6'd20;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [7:0]  FUNC_EXC_FLAG = 8'h80;
   localparam logic [7:0]  EXC_CODE      = 8'h01;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC_RX,
      ST_COMPARE,
      ST_CRC_REPLY,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic crc_init;
      logic crc_step;
      logic reply_mode;
      logic idx_clr;
      logic idx_inc;
      logic frame_clr;
   } cmd_type;

   typedef struct packed {
      logic frame_start;
      logic crc_match;
      logic idx_crc_last;
      logic idx_reply_last;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/mrsfc_datapath.sv @@
// ----------------------------------------------------------------------------
// mrsfc_datapath
// Frame store, configuration registers, byte-wide CRC unit and reply mux.
// ----------------------------------------------------------------------------
`default_nettype none

module mrsfc_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire logic [1:0]           req_kind,
   input  wire logic [7:0]           req_rx_byte,
   input  wire logic                 csr_we,
   input  wire logic                 csr_index,
   input  wire logic [7:0]           csr_wdata,
   input  wire mrsfc_pkg::cmd_type   cmd,
   output mrsfc_pkg::status_type     status,
   output logic [7:0]                rsp_reply_byte,
   output logic                      rsp_reply_last
);

   // one CRC-16/MODBUS byte update: eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ mrsfc_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   logic [7:0]                      slave_address_ff, slave_address_in;
   logic [5:0]                      frame_limit_ff, frame_limit_in;
   logic                            gap_pending_ff, gap_pending_in;
   logic [mrsfc_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                            ovf_ff, ovf_in;
   logic [7:0]                      rx_byte_ff [mrsfc_pkg::KEEP_BYTES];
   logic [15:0]                     crc_ff, crc_in;
   logic [mrsfc_pkg::IDX_W-1:0]     idx_ff, idx_in;

   logic [7:0]  rx_val [mrsfc_pkg::KEEP_BYTES];
   logic [7:0]  reply_sel;
   logic [7:0]  crc_data;
   logic        frame_ok;
   logic        gap15_open;
   logic        store_byte;
   logic        store_slot;

   // positions beyond the fill count read as zero
   always_comb begin
      for (int i = 0; i < mrsfc_pkg::KEEP_BYTES; i++) begin
         rx_val[i] = (i < int'(count_ff)) ? rx_byte_ff[i] : 8'h00;
      end
   end

   // frame acceptance on the closing gap
   assign frame_ok   = (count_ff != '0) && !ovf_ff &&
                       (int'(count_ff) <= int'(frame_limit_ff)) &&
                       (rx_val[0] == slave_address_ff);
   assign gap15_open = take && (req_kind == mrsfc_pkg::KIND_GAP15) && !gap_pending_ff;
   assign store_byte = take && (req_kind == mrsfc_pkg::KIND_BYTE) && !gap_pending_ff;
   assign store_slot = store_byte && (int'(count_ff) < mrsfc_pkg::KEEP_BYTES);

   // exception reply byte at the current index
   always_comb begin
      case (idx_ff)
         3'd0:    reply_sel = slave_address_ff;
         3'd1:    reply_sel = rx_val[1];
         3'd2:    reply_sel = rx_val[2] + mrsfc_pkg::FUNC_EXC_FLAG;
         3'd3:    reply_sel = rx_val[3];
         3'd4:    reply_sel = mrsfc_pkg::EXC_CODE;
         3'd5:    reply_sel = crc_ff[7:0];
         3'd6:    reply_sel = crc_ff[15:8];
         default: reply_sel = 8'h00;
      endcase
   end

   assign crc_data = cmd.reply_mode ? reply_sel : rx_val[idx_ff];

   // next values of configuration and frame state
   always_comb begin
      slave_address_in = slave_address_ff;
      frame_limit_in   = frame_limit_ff;
      gap_pending_in   = gap_pending_ff;
      count_in         = count_ff;
      ovf_in           = ovf_ff;
      crc_in           = crc_ff;
      idx_in           = idx_ff;

      if (csr_we) begin
         case (csr_index)
            mrsfc_pkg::CSR_SLAVE_ADDRESS: slave_address_in = csr_wdata;
            mrsfc_pkg::CSR_FRAME_LIMIT:   frame_limit_in   = csr_wdata[5:0];
            default: ;
         endcase
      end

      // store a byte or flag the frame as too long
      if (store_byte) begin
         if (int'(count_ff) < mrsfc_pkg::RX_DEPTH) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (take && (req_kind == mrsfc_pkg::KIND_GAP35)) begin
         gap_pending_in = 1'b0;
      end

      // close the frame; drop it at once when it is not accepted
      if (gap15_open) begin
         gap_pending_in = 1'b1;
         if (!frame_ok) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end

      if (cmd.frame_clr) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end

      // CRC unit and byte index
      if (cmd.crc_init) begin
         crc_in = mrsfc_pkg::CRC_INIT;
         idx_in = '0;
      end
      if (cmd.crc_step) begin
         crc_in = crc_byte(crc_ff, crc_data);
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= mrsfc_pkg::SLAVE_ADDRESS_RESET;
         frame_limit_ff   <= mrsfc_pkg::FRAME_LIMIT_RESET;
         gap_pending_ff   <= 1'b0;
         count_ff         <= '0;
         ovf_ff           <= 1'b0;
         idx_ff           <= '0;
      end else begin
         slave_address_ff <= slave_address_in;
         frame_limit_ff   <= frame_limit_in;
         gap_pending_ff   <= gap_pending_in;
         count_ff         <= count_in;
         ovf_ff           <= ovf_in;
         idx_ff           <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (store_slot) begin
         rx_byte_ff[count_ff[mrsfc_pkg::IDX_W-1:0]] <= req_rx_byte;
      end
   end

   // status to the controller
   assign status.frame_start    = gap15_open && frame_ok;
   assign status.crc_match      = (crc_ff == {rx_val[6], rx_val[5]});
   assign status.idx_crc_last   = (idx_ff == mrsfc_pkg::IDX_CRC_LAST);
   assign status.idx_reply_last = (idx_ff == mrsfc_pkg::IDX_REPLY_LAST);

   assign rsp_reply_byte = reply_sel;
   assign rsp_reply_last = (idx_ff == mrsfc_pkg::IDX_REPLY_LAST);

endmodule

`default_nettype wire

@@ rtl/mrsfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrsfc_ctrl
// Sequencer for frame check, reply CRC and reply transmission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mrsfc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mrsfc_pkg::status_type  status,
   input  wire logic                   rsp_stall,
   output mrsfc_pkg::cmd_type          cmd,
   output logic                        req_stall,
   output logic                        rsp_valid
);

   mrsfc_pkg::state_type state_ff, state_in;

   logic in_idle;
   logic in_crc_rx;
   logic in_compare;
   logic send_done;
   logic no_entry;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrsfc_pkg::ST_IDLE: begin
            if (status.frame_start) state_in = mrsfc_pkg::ST_CRC_RX;
         end
         mrsfc_pkg::ST_CRC_RX: begin
            if (status.idx_crc_last) state_in = mrsfc_pkg::ST_COMPARE;
         end
         mrsfc_pkg::ST_COMPARE: begin
            state_in = status.crc_match ? mrsfc_pkg::ST_IDLE : mrsfc_pkg::ST_CRC_REPLY;
         end
         mrsfc_pkg::ST_CRC_REPLY: begin
            if (status.idx_crc_last) state_in = mrsfc_pkg::ST_SEND;
         end
         mrsfc_pkg::ST_SEND: begin
            if (!rsp_stall && status.idx_reply_last) state_in = mrsfc_pkg::ST_IDLE;
         end
         default: state_in = mrsfc_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         mrsfc_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.crc_init = status.frame_start;
         end
         mrsfc_pkg::ST_CRC_RX: begin
            cmd.crc_step = 1'b1;
         end
         mrsfc_pkg::ST_COMPARE: begin
            cmd.frame_clr = status.crc_match;
            cmd.crc_init  = !status.crc_match;
         end
         mrsfc_pkg::ST_CRC_REPLY: begin
            cmd.crc_step   = 1'b1;
            cmd.reply_mode = 1'b1;
            cmd.idx_clr    = status.idx_crc_last;
         end
         mrsfc_pkg::ST_SEND: begin
            rsp_valid     = 1'b1;
            cmd.idx_inc   = !rsp_stall;
            cmd.frame_clr = !rsp_stall && status.idx_reply_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrsfc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // state decodes for the checks below
   assign in_idle    = (state_ff == mrsfc_pkg::ST_IDLE);
   assign in_crc_rx  = (state_ff == mrsfc_pkg::ST_CRC_RX);
   assign in_compare = (state_ff == mrsfc_pkg::ST_COMPARE);
   assign send_done  = (state_ff == mrsfc_pkg::ST_SEND) && !rsp_stall &&
                       status.idx_reply_last;
   assign no_entry   = !in_crc_rx && !status.frame_start;

   // the final reply byte returns the sequencer to idle
   `ASSERT_NEXT(a_send_done, clock, reset, send_done, in_idle, "reply did not end")
   // the compare step is never followed by another compare step
   `ASSERT_NEXT(a_compare_once, clock, reset, in_compare, !in_compare, "compare step repeated")
   // a check starts only from an accepted closing gap
   `ASSERT_CLKED(a_check_entry, clock, reset, no_entry |=> !in_crc_rx, "check without frame")

endmodule

`default_nettype wire

@@ rtl/modbus_rtu_slave_frame_checker.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_checker
// Modbus RTU slave receiver with CRC-16 check and exception reply.
// ----------------------------------------------------------------------------
// Byte and gap requests are taken one per cycle while the block is idle. A
// 1.5-character gap that closes an accepted frame raises req_stall while a
// byte-per-cycle CRC unit walks the five checked bytes and a compare step
// runs; a CRC-good frame is then done. A bad frame reuses the same CRC unit
// over the reply header and then sends the 7 reply bytes, one per cycle
// that rsp_stall is low, so such a gap holds the request side until the
// last reply byte is taken. Only the first seven frame bytes are kept; later
// bytes count toward the length and the 32-byte store limit. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_slave_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_reply_byte,
   output logic             rsp_reply_last,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   mrsfc_pkg::cmd_type    cmd;
   mrsfc_pkg::status_type status;
   logic                  take;

   // request accepted this cycle
   assign take = req_valid && !req_stall;

   mrsfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   mrsfc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .req_kind       (req_kind),
      .req_rx_byte    (req_rx_byte),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_reply_byte (rsp_reply_byte),
      .rsp_reply_last (rsp_reply_last)
   );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the Modbus RTU slave frame checker from its ports. Requests (bytes,
// 1.5 and 3.5 character gaps, the reserved kind) go in through a valid/stall
// channel. A scoreboard class keeps its own copy of the receive state and the
// registers, predicts each exception reply, and checks every reply byte in
// order. After a short directed part, mostly well-formed frames with random
// content run under several register settings, with random idling on both
// sides except in one steady phase.
// ----------------------------------------------------------------------------

module tb_top;

   localparam logic [1:0] KIND_RESERVED = 2'd3;
   localparam int         SETTLE_CYCLES = 24;
   localparam int         RUN_LIMIT     = 8 * 200000;
   localparam int         PHASES        = 6;
   localparam int         PHASE_ITEMS   = 36;
   localparam int         FRAME_MAX     = mrsfc_pkg::RX_DEPTH + 4;

   typedef logic [7:0] crc_span_type [5];

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } reply_beat_type;

   // Scoreboard: receive state, register copy and the replies still owed
   class exception_reply_model;
      logic [7:0]     slave_address;
      logic [5:0]     frame_limit;
      bit             gap_pending;
      logic [7:0]     rx_store [mrsfc_pkg::RX_DEPTH];
      int             rx_count;
      bit             overflowed;
      reply_beat_type reply_due [$];
      int             mismatches;

      function new();
         slave_address = mrsfc_pkg::SLAVE_ADDRESS_RESET;
         frame_limit   = mrsfc_pkg::FRAME_LIMIT_RESET;
         gap_pending   = 1'b0;
         mismatches    = 0;
         clear_frame();
      endfunction

      // CRC-16/MODBUS over five bytes
      static function logic [15:0] crc16(crc_span_type span);
         logic [15:0] crc;
         int          i;
         int          b;
         crc = mrsfc_pkg::CRC_INIT;
         for (i = 0; i < 5; i++) begin
            crc = crc ^ {8'h00, span[i]};
            for (b = 0; b < 8; b++) begin
               crc = crc[0] ? ((crc >> 1) ^ mrsfc_pkg::CRC_POLY) : (crc >> 1);
            end
         end
         return crc;
      endfunction

      function void clear_frame();
         int i;
         for (i = 0; i < mrsfc_pkg::RX_DEPTH; i++) begin
            rx_store[i] = 8'h00;
         end
         rx_count   = 0;
         overflowed = 1'b0;
      endfunction

      function void set_register(logic idx, logic [7:0] value);
         if (idx == mrsfc_pkg::CSR_SLAVE_ADDRESS) begin
            slave_address = value;
         end else begin
            frame_limit = value[5:0];
         end
      endfunction

      function int pending();
         return reply_due.size();
      endfunction

      // Advance the receive state by one accepted request
      function void take_request(logic [1:0] kind, logic [7:0] rx_byte);
         crc_span_type   span;
         logic [15:0]    crc;
         logic [7:0]     reply [7];
         reply_beat_type beat;
         int             k;
         case (kind)
            mrsfc_pkg::KIND_BYTE: begin
               // drop bytes between the 1.5 and the 3.5 gap
               if (!gap_pending) begin
                  if (rx_count < mrsfc_pkg::RX_DEPTH) begin
                     rx_store[rx_count] = rx_byte;
                     rx_count++;
                  end else begin
                     overflowed = 1'b1;
                  end
               end
            end
            mrsfc_pkg::KIND_GAP35: begin
               gap_pending = 1'b0;
            end
            mrsfc_pkg::KIND_GAP15: begin
               if (!gap_pending) begin
                  gap_pending = 1'b1;
                  if (rx_count != 0 && !overflowed && rx_count <= frame_limit &&
                      rx_store[0] == slave_address) begin
                     for (k = 0; k < 5; k++) begin
                        span[k] = rx_store[k];
                     end
                     crc = crc16(span);
                     // build the exception reply on a CRC mismatch
                     if (crc != {rx_store[6], rx_store[5]}) begin
                        reply[0] = slave_address;
                        reply[1] = rx_store[1];
                        reply[2] = rx_store[2] + mrsfc_pkg::FUNC_EXC_FLAG;
                        reply[3] = rx_store[3];
                        reply[4] = mrsfc_pkg::EXC_CODE;
                        for (k = 0; k < 5; k++) begin
                           span[k] = reply[k];
                        end
                        crc      = crc16(span);
                        reply[5] = crc[7:0];
                        reply[6] = crc[15:8];
                        for (k = 0; k < 7; k++) begin
                           beat.data = reply[k];
                           beat.last = (k == 6);
                           reply_due.push_back(beat);
                        end
                     end
                  end
                  clear_frame();
               end
            end
            default: begin
               // reserved kind: ignore
            end
         endcase
      endfunction

      // Compare one reply byte with the oldest one owed
      function void check_reply(logic [7:0] data, logic last);
         reply_beat_type want;
         if (reply_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected reply: expected none, actual byte %h last %b",
                     $time, data, last);
            return;
         end
         want = reply_due.pop_front();
         if (data !== want.data) begin
            mismatches++;
            $display("%0t: reply_byte mismatch: expected %h, actual %h",
                     $time, want.data, data);
         end
         if (last !== want.last) begin
            mismatches++;
            $display("%0t: reply_last mismatch: expected %b, actual %b",
                     $time, want.last, last);
         end
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic [1:0] req_kind       = mrsfc_pkg::KIND_BYTE;
   logic [7:0] req_rx_byte    = 8'h00;
   logic       rsp_stall      = 1'b0;
   logic       csr_we         = 1'b0;
   logic       csr_index      = mrsfc_pkg::CSR_SLAVE_ADDRESS;
   logic [7:0] csr_wdata      = 8'h00;
   wire        req_stall;
   wire        rsp_valid;
   wire  [7:0] rsp_reply_byte;
   wire        rsp_reply_last;

   exception_reply_model replies;
   int                   requests_sent = 0;
   bit                   steady        = 1'b0;

   modbus_rtu_slave_frame_checker u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reply_byte (rsp_reply_byte),
      .rsp_reply_last (rsp_reply_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Check accepted replies and stall the reply side at random
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         replies.check_reply(rsp_reply_byte, rsp_reply_last);
      end
      rsp_stall <= !steady && ($urandom_range(99) < 11);
   end

   // Present one request, idling first at random, and hold it until taken
   task automatic send_request(logic [1:0] kind, logic [7:0] rx_byte);
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= rx_byte;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      replies.take_request(kind, rx_byte);
      requests_sent++;
   endtask

   // Send a frame of len bytes closed by a 1.5 gap
   task automatic send_frame(int len, bit fix_crc, bit to_me);
      logic [7:0]   frame [FRAME_MAX];
      crc_span_type span;
      logic [15:0]  crc;
      int           i;
      for (i = 0; i < len; i++) begin
         frame[i] = 8'($urandom_range(255));
      end
      if (to_me) begin
         frame[0] = replies.slave_address;
      end
      if (fix_crc && len >= 7) begin
         for (i = 0; i < 5; i++) begin
            span[i] = frame[i];
         end
         crc      = exception_reply_model::crc16(span);
         frame[5] = crc[7:0];
         frame[6] = crc[15:8];
      end
      for (i = 0; i < len; i++) begin
         send_request(mrsfc_pkg::KIND_BYTE, frame[i]);
      end
      send_request(mrsfc_pkg::KIND_GAP15, 8'($urandom_range(255)));
   endtask

   // Hold the sender until every reply has come and the block has settled
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (replies.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(logic [7:0] address, logic [7:0] limit);
      csr_we    <= 1'b1;
      csr_index <= mrsfc_pkg::CSR_SLAVE_ADDRESS;
      csr_wdata <= address;
      @(posedge clock);
      replies.set_register(mrsfc_pkg::CSR_SLAVE_ADDRESS, address);
      csr_index <= mrsfc_pkg::CSR_FRAME_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      replies.set_register(mrsfc_pkg::CSR_FRAME_LIMIT, limit);
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed frames, with noise and broken endings mixed in
   task automatic random_traffic(int stop_at);
      int pick;
      int len;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
         end else begin
            len = ($urandom_range(99) < 10) ? $urandom_range(30, mrsfc_pkg::RX_DEPTH + 2)
                                            : $urandom_range(1, 10);
            send_frame(len, 1'($urandom_range(1)), $urandom_range(99) < 85);
            pick = $urandom_range(99);
            if (pick < 10) begin
               send_request(mrsfc_pkg::KIND_GAP15, 8'($urandom_range(255)));
            end else if (pick < 20) begin
               send_request(mrsfc_pkg::KIND_BYTE, 8'($urandom_range(255)));
            end
            // leave out the 3.5 gap now and then
            if ($urandom_range(99) < 93) begin
               send_request(mrsfc_pkg::KIND_GAP35, 8'($urandom_range(255)));
            end
         end
      end
   endtask

   initial begin
      #(RUN_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   initial begin
      int          phase;
      logic [7:0]  address;
      logic [7:0]  limit;
      replies = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: gaps with nothing pending, empty and repeated gaps
      send_request(mrsfc_pkg::KIND_GAP35, 8'h00);
      send_request(mrsfc_pkg::KIND_GAP15, 8'hFF);
      send_request(mrsfc_pkg::KIND_GAP15, 8'h00);
      send_request(mrsfc_pkg::KIND_BYTE, 8'hFF);
      send_request(mrsfc_pkg::KIND_GAP35, 8'hFF);
      send_request(KIND_RESERVED, 8'hAA);
      // short frame: unwritten bytes read as zero, CRC fails
      send_request(mrsfc_pkg::KIND_BYTE, 8'h01);
      send_request(mrsfc_pkg::KIND_BYTE, 8'hFF);
      send_request(mrsfc_pkg::KIND_GAP15, 8'h55);
      send_request(mrsfc_pkg::KIND_GAP35, 8'h00);
      // wrong address, then a frame with a good CRC
      send_request(mrsfc_pkg::KIND_BYTE, 8'h00);
      send_request(mrsfc_pkg::KIND_GAP15, 8'h00);
      send_request(mrsfc_pkg::KIND_GAP35, 8'h00);
      send_frame(7, 1'b1, 1'b1);
      send_request(mrsfc_pkg::KIND_GAP35, 8'h00);

      // random frames under several register settings
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            drain_replies();
            address = 8'($urandom_range(255));
            case (phase)
               1:       begin address = 8'h00; limit = 8'h01; end
               2:       begin address = 8'hFF; limit = 8'h20; end
               3:       limit = 8'hC0;
               4:       limit = 8'hFF;
               default: limit = 8'h07;
            endcase
            write_registers(address, limit);
         end
         steady = (phase == 2);
         random_traffic(requests_sent + PHASE_ITEMS);
      end
      steady = 1'b0;

      drain_replies();
      if (replies.mismatches == 0 && replies.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

@@ modbus_rtu_slave_frame_checker.f @@
+incdir+rtl
rtl/mrsfc_pkg.sv
rtl/mrsfc_datapath.sv
rtl/mrsfc_ctrl.sv
rtl/modbus_rtu_slave_frame_checker.sv
dv/tb_top.sv
